FILE: rtl/tfc_pkg.sv
// Shared constants and types of the telecontrol frame checker.
`timescale 1ns / 1ps

package tfc_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 4;
  localparam int unsigned SeqW    = 15;
  localparam int unsigned MarkerW = 32;

  // Frame constants.
  localparam logic [ByteW-1:0]   StartByte   = 8'h68;
  localparam logic [CountW-1:0]  CountMax    = 9'd511;
  localparam logic [MarkerW-1:0] MarkerReset = 32'hBAAD_F00D;
  localparam logic [ByteW-1:0]   CtrlU0      = 8'h07;
  localparam logic [ByteW-1:0]   CtrlU1      = 8'h0B;
  localparam logic [ByteW-1:0]   CtrlU2      = 8'h13;
  localparam logic [ByteW-1:0]   TypeHigh    = 8'h80;

  // Byte positions inside a frame.
  localparam logic [CountW-1:0] PosStart = 9'd0;
  localparam logic [CountW-1:0] PosLen   = 9'd1;
  localparam logic [CountW-1:0] PosCtrl0 = 9'd2;
  localparam logic [CountW-1:0] PosCtrl1 = 9'd3;
  localparam logic [CountW-1:0] PosSeqLo = 9'd4;
  localparam logic [CountW-1:0] PosSeqHi = 9'd5;
  localparam logic [CountW-1:0] PosType  = 9'd6;

  // Frame length limit.
  localparam logic [CountW:0] MinLen  = 10'd6;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk        = 4'd0,
    StShort     = 4'd1,
    StBadStart  = 4'd2,
    StLenErr    = 4'd3,
    StChecksum  = 4'd4,
    StCtrlBits  = 4'd5,
    StUCtrl     = 4'd6,
    StBadType   = 4'd7,
    StMarker    = 4'd8
  } status_e;

endpackage

FILE: rtl/telecontrol_frame_checker.sv
// Telecontrol frame checker: per-byte frame scan with one status per frame.
// Throughput: one byte per cycle, including across frame boundaries, while the result stream is not stalled.
// The status is loaded into the result register once the last byte in the input register can advance.
// The input register and the result register are split by combinational scan logic.
// Reset clears all per-frame state and loads the marker word with 0xBAADF00D.
// A stalled result holds only the last byte of the next frame in the input register.
`timescale 1ns / 1ps

module telecontrol_frame_checker
  import tfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream: tdata[7:0] frame_byte; tlast last_byte.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  // Result stream: tdata[3:0] status, tdata[18:4] receive_sequence, rest zero.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,
  // Marker word register.
  input  logic               cfg_we_i,
  input  logic [MarkerW-1:0] cfg_wdata_i
);

  // Configuration register.
  logic [MarkerW-1:0] marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MarkerReset;
    end else if (cfg_we_i) begin
      marker_q <= cfg_wdata_i;
    end
  end

  // Input register.
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             advance;
  logic             accept;

  // Non-final bytes always move on; a final byte waits for a free result slot.
  assign advance = in_valid_q && (!in_last_q || !m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Per-frame state.
  logic [CountW-1:0]  count_q, count_d;
  logic               start_ok_q, start_ok_d;
  logic [ByteW-1:0]   decl_len_q, decl_len_d;
  logic [ByteW-1:0]   sum_q, sum_d;
  logic [ByteW-1:0]   ctrl0_q, ctrl0_d;
  logic [ByteW-1:0]   ctrl1_q, ctrl1_d;
  logic [ByteW-1:0]   seq_lo_q, seq_lo_d;
  logic [ByteW-1:0]   seq_hi_q, seq_hi_d;
  logic [ByteW-1:0]   type_q, type_d;
  logic [23:0]        hist_q, hist_d;
  logic               marker_seen_q, marker_seen_d;

  logic [MarkerW-1:0] window;
  logic               marker_hit;
  logic [CountW:0]    frame_len;
  logic [CountW:0]    expect_len;
  logic               long_frame;
  status_e            status;
  logic [SeqW-1:0]    seq;

  // Header capture and running checks for the byte in the input register.
  always_comb begin
    start_ok_d = (count_q == PosStart) ? (in_byte_q == StartByte) : start_ok_q;
    decl_len_d = (count_q == PosLen)   ? in_byte_q : decl_len_q;
    ctrl0_d    = (count_q == PosCtrl0) ? in_byte_q : ctrl0_q;
    ctrl1_d    = (count_q == PosCtrl1) ? in_byte_q : ctrl1_q;
    seq_lo_d   = (count_q == PosSeqLo) ? in_byte_q : seq_lo_q;
    seq_hi_d   = (count_q == PosSeqHi) ? in_byte_q : seq_hi_q;
    type_d     = (count_q == PosType)  ? in_byte_q : type_q;

    window        = {hist_q, in_byte_q};
    marker_hit    = (count_q >= PosCtrl1) && (window == marker_q);
    marker_seen_d = marker_seen_q || marker_hit;
    hist_d        = window[23:0];

    sum_d   = (count_q >= PosCtrl0) ? (sum_q + in_byte_q) : sum_q;
    count_d = (count_q < CountMax) ? (count_q + 9'd1) : count_q;
  end

  // Status priority for the final byte.
  always_comb begin
    frame_len  = {1'b0, count_q} + 10'd1;
    expect_len = {2'b00, decl_len_d} + 10'd2;
    long_frame = frame_len > MinLen;

    if (frame_len < MinLen) begin
      status = StShort;
    end else if (!start_ok_d) begin
      status = StBadStart;
    end else if (frame_len != expect_len) begin
      status = StLenErr;
    end else if (long_frame && (sum_q != in_byte_q)) begin
      status = StChecksum;
    end else if (ctrl0_d[0] && ctrl1_d[0]) begin
      status = StCtrlBits;
    end else if ((ctrl0_d == CtrlU0) || (ctrl0_d == CtrlU1) || (ctrl0_d == CtrlU2)) begin
      status = StUCtrl;
    end else if (long_frame && ((type_d == '0) || (type_d >= TypeHigh))) begin
      status = StBadType;
    end else if (long_frame && marker_seen_d) begin
      status = StMarker;
    end else begin
      status = StOk;
    end

    seq = (status == StOk) ? {seq_hi_d, seq_lo_d[7:1]} : '0;
  end

  // Frame state update; the final byte returns everything to its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      start_ok_q    <= 1'b0;
      decl_len_q    <= '0;
      sum_q         <= '0;
      ctrl0_q       <= '0;
      ctrl1_q       <= '0;
      seq_lo_q      <= '0;
      seq_hi_q      <= '0;
      type_q        <= '0;
      hist_q        <= '0;
      marker_seen_q <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        count_q       <= '0;
        start_ok_q    <= 1'b0;
        decl_len_q    <= '0;
        sum_q         <= '0;
        ctrl0_q       <= '0;
        ctrl1_q       <= '0;
        seq_lo_q      <= '0;
        seq_hi_q      <= '0;
        type_q        <= '0;
        hist_q        <= '0;
        marker_seen_q <= 1'b0;
      end else begin
        count_q       <= count_d;
        start_ok_q    <= start_ok_d;
        decl_len_q    <= decl_len_d;
        sum_q         <= sum_d;
        ctrl0_q       <= ctrl0_d;
        ctrl1_q       <= ctrl1_d;
        seq_lo_q      <= seq_lo_d;
        seq_hi_q      <= seq_hi_d;
        type_q        <= type_d;
        hist_q        <= hist_d;
        marker_seen_q <= marker_seen_d;
      end
    end
  end

  // Result register.
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [SeqW-1:0]    out_seq_q;
  logic               load_result;

  assign load_result = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_status_q <= status;
      out_seq_q    <= seq;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_seq_q, out_status_q};

endmodule

FILE: rtl/tfc_checker.sv
// Port-level assertions for the telecontrol frame checker, bound to the top level.
`timescale 1ns / 1ps

module tfc_checker
  import tfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // A stalled result keeps its request and its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // The status code stays within the defined set and the padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[3:0] <= StMarker) && (m_axis_tdata_o[23:19] == 5'd0)))
    else $error("result status out of range");

  // The receive sequence is only reported for a clean frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[3:0] != StOk)) |-> (m_axis_tdata_o[18:4] == 15'd0))
    else $error("sequence reported for a failed frame");

  // A fresh result follows an accepted request that carried the last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, 2))
    else $error("result without a final byte");

endmodule

bind telecontrol_frame_checker tfc_checker u_tfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
